FILE: design/smeu_pkg.sv
// shared types, codes and sizes of the stack machine execute unit
package smeu_pkg;

	localparam int STACK_DEPTH  = 256;
	localparam int LOCALS_DEPTH = 256;
	localparam int SP_W         = $clog2(STACK_DEPTH + 1);
	localparam int LOC_AW       = (LOCALS_DEPTH > 1) ? $clog2(LOCALS_DEPTH) : 1;
	localparam int DATA_W       = 64;
	localparam int PC_W         = 16;
	localparam int NOV          = 6;

	localparam logic [5:0] OP_PUSH  = 6'd0;
	localparam logic [5:0] OP_ADD   = 6'd1;
	localparam logic [5:0] OP_SUB   = 6'd2;
	localparam logic [5:0] OP_MUL   = 6'd3;
	localparam logic [5:0] OP_DIV   = 6'd4;
	localparam logic [5:0] OP_EMIT  = 6'd5;
	localparam logic [5:0] OP_NOP   = 6'd6;
	localparam logic [5:0] OP_SWAP  = 6'd7;
	localparam logic [5:0] OP_DUP   = 6'd8;
	localparam logic [5:0] OP_DUPX1 = 6'd9;
	localparam logic [5:0] OP_DUPX2 = 6'd10;
	localparam logic [5:0] OP_DUP2  = 6'd11;
	localparam logic [5:0] OP_D2X1  = 6'd12;
	localparam logic [5:0] OP_D2X2  = 6'd13;
	localparam logic [5:0] OP_HJUMP = 6'd14;
	localparam logic [5:0] OP_LOAD  = 6'd15;
	localparam logic [5:0] OP_SAVE  = 6'd16;
	localparam logic [5:0] OP_IFEQ  = 6'd17;
	localparam logic [5:0] OP_IFNE  = 6'd18;
	localparam logic [5:0] OP_IFLT  = 6'd19;
	localparam logic [5:0] OP_IFLE  = 6'd20;
	localparam logic [5:0] OP_IFGT  = 6'd21;
	localparam logic [5:0] OP_IFGE  = 6'd22;
	localparam logic [5:0] OP_GOTO  = 6'd23;
	localparam logic [5:0] OP_AND   = 6'd24;
	localparam logic [5:0] OP_OR    = 6'd25;
	localparam logic [5:0] OP_XOR   = 6'd26;
	localparam logic [5:0] OP_SHL   = 6'd27;
	localparam logic [5:0] OP_SHR   = 6'd28;
	localparam logic [5:0] OP_USHR  = 6'd29;
	localparam logic [5:0] OP_I2L   = 6'd30;
	localparam logic [5:0] OP_I2B   = 6'd31;
	localparam logic [5:0] OP_I2C   = 6'd32;
	localparam logic [5:0] OP_I2S   = 6'd33;
	localparam logic [5:0] OP_L2I   = 6'd34;
	localparam logic [5:0] OP_NEG   = 6'd35;
	localparam logic [5:0] OP_HALT  = 6'd36;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	// stack movement: push moves entries away from the top
	localparam logic [2:0] SH_HOLD  = 3'd0;
	localparam logic [2:0] SH_PUSH1 = 3'd1;
	localparam logic [2:0] SH_PUSH2 = 3'd2;
	localparam logic [2:0] SH_POP1  = 3'd3;
	localparam logic [2:0] SH_POP2  = 3'd4;

	typedef struct packed {
		logic [5:0]               action;
		logic signed [DATA_W-1:0] immediate;
	} in_item_t;

	typedef struct packed {
		logic [PC_W-1:0]          next_pc;
		logic signed [DATA_W-1:0] top_value;
		logic [SP_W-1:0]          stack_depth;
		logic                     print_valid;
		logic signed [DATA_W-1:0] print_value;
		logic [1:0]               run_status;
		logic signed [DATA_W-1:0] return_value;
	} out_item_t;

	typedef struct packed {
		logic [2:0]        shift;
		logic              ov_en;
		logic [DATA_W-1:0] ov_val;
	} cell_ctl_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: design/smeu_ram.sv
// generic single write, single read memory with registered read data
module smeu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/smeu_cell.sv
// one operand stack entry, moving with its neighbours on push and pop
module smeu_cell
	import smeu_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] up1,
	input  logic [DATA_W-1:0] up2,
	input  logic [DATA_W-1:0] dn1,
	input  logic [DATA_W-1:0] dn2,
	output logic [DATA_W-1:0] value
);

	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] shifted;

	always_comb begin
		case (ctl.shift)
			SH_PUSH1: shifted = up1;
			SH_PUSH2: shifted = up2;
			SH_POP1:  shifted = dn1;
			SH_POP2:  shifted = dn2;
			default:  shifted = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= ctl.ov_en ? ctl.ov_val : shifted;
	end

	assign value = value_q;

endmodule

FILE: design/smeu_div.sv
// signed 64-bit divider, one quotient bit per cycle on magnitudes
module smeu_div
	import smeu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] mb_q;
	logic [DATA_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
			quo_q <= req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
			mb_q  <= req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DATA_W'(trial - {1'b0, mb_q}) : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

FILE: design/stack_machine_execute_unit.sv
// stack machine execute unit: sequencer, chain of stack cells, locals memory
// a request passes through the exec state and the response state before its result is
// offered; the next request is taken once the sequencer is back in idle and the result slot is free
// mul goes through a multiply state (one 32x32 multiplier over three partial products),
// div waits in a divide state (one quotient bit a cycle), load waits in a load state (memory read)
// reset clears pc, stack pointer, status, program length and the locals valid bits;
// stack cell contents are undefined until pushed
module stack_machine_execute_unit
	import smeu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_item,
	input  logic            cfg_we,
	input  logic [PC_W-1:0] cfg_wdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [5:0]        op_q;
	logic [DATA_W-1:0] imm_q;
	logic [SP_W-1:0]   sp_q, sp_d;
	logic [PC_W-1:0]   pc_q, pc_d, pc_inc, pc_sat;
	logic [1:0]        term_q, term_d;
	logic [DATA_W-1:0] ret_q, ret_d;
	logic              pv_q, pv_d;
	logic [DATA_W-1:0] pval_q, pval_d;
	logic [PC_W-1:0]   plen_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic [LOCALS_DEPTH-1:0] lvalid_q;
	logic [1:0]        mcnt_q, mcnt_d;
	logic [DATA_W-1:0] prod_q, acc_q, acc_d;
	logic [31:0]       mx, my;

	logic [DATA_W-1:0] cv [STACK_DEPTH];
	cell_ctl_t         ctl [STACK_DEPTH];
	logic [2:0]        shift_c;
	logic [NOV-1:0]    ov_en_c;
	logic [DATA_W-1:0] ov_val_c [NOV];

	logic [DATA_W-1:0] t0, t1, t2, t3, top, alu_r, load_val, mul_r;
	logic [5:0]        sh;
	logic              taken, idx_ok, lwe;
	logic [LOC_AW-1:0] lidx;
	logic [DATA_W-1:0] rdata;
	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              post_end;

	assign t0  = cv[0];
	assign t1  = cv[1];
	assign t2  = cv[2];
	assign t3  = cv[3];
	assign top = (sp_q != '0) ? t0 : '0;
	assign sh  = t0[5:0];

	assign pc_inc = (pc_q == '1) ? pc_q : pc_q + PC_W'(1);
	assign pc_sat = (imm_q[DATA_W-1:PC_W] != '0) ? '1 : imm_q[PC_W-1:0];
	assign idx_ok = imm_q < DATA_W'(LOCALS_DEPTH);
	assign lidx   = imm_q[LOC_AW-1:0];

	always_comb begin
		case (op_q)
			OP_ADD:  alu_r = t1 + t0;
			OP_SUB:  alu_r = t1 - t0;
			OP_AND:  alu_r = t1 & t0;
			OP_OR:   alu_r = t1 | t0;
			OP_XOR:  alu_r = t1 ^ t0;
			OP_SHL:  alu_r = t1 << sh;
			OP_SHR:  alu_r = DATA_W'($signed(t1) >>> sh);
			OP_USHR: alu_r = t1 >> sh;
			OP_I2L:  alu_r = {{32{t0[31]}}, t0[31:0]};
			OP_L2I:  alu_r = {{32{t0[31]}}, t0[31:0]};
			OP_I2B:  alu_r = {{56{t0[7]}}, t0[7:0]};
			OP_I2C:  alu_r = {48'd0, t0[15:0]};
			OP_I2S:  alu_r = {{48{t0[15]}}, t0[15:0]};
			OP_NEG:  alu_r = DATA_W'(0) - t0;
			default: alu_r = t0;
		endcase
	end

	always_comb begin
		case (op_q)
			OP_IFEQ: taken = t1 == t0;
			OP_IFNE: taken = t1 != t0;
			OP_IFLT: taken = $signed(t1) < $signed(t0);
			OP_IFLE: taken = $signed(t1) <= $signed(t0);
			OP_IFGT: taken = $signed(t1) > $signed(t0);
			default: taken = $signed(t1) >= $signed(t0);
		endcase
	end

	// low 64 bits of the product from three 32x32 partial products
	assign mx    = (mcnt_q == 2'd2) ? t1[63:32] : t1[31:0];
	assign my    = (mcnt_q == 2'd1) ? t0[63:32] : t0[31:0];
	assign mul_r = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};

	assign load_val = lvalid_q[lidx] ? rdata : '0;

	always_comb begin
		state_d = state_q;
		sp_d    = sp_q;
		pc_d    = pc_q;
		term_d  = term_q;
		ret_d   = ret_q;
		pv_d    = pv_q;
		pval_d  = pval_q;
		mcnt_d  = mcnt_q;
		acc_d   = acc_q;
		shift_c = SH_HOLD;
		ov_en_c = '0;
		for (int k = 0; k < NOV; k++) begin
			ov_val_c[k] = '0;
		end
		lwe        = 1'b0;
		dreq.start = 1'b0;
		dreq.dividend = t1;
		dreq.divisor  = t0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = S_EXEC;
					pv_d    = 1'b0;
					pval_d  = '0;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
				if (term_q != ST_RUN) begin
					state_d = S_RESP;
				end else if (pc_q >= plen_q) begin
					term_d = ST_END;
					ret_d  = top;
				end else begin
					pc_d = pc_inc;
					unique case (op_q) inside
						OP_PUSH: begin
							if (sp_q < SP_W'(STACK_DEPTH)) begin
								shift_c = SH_PUSH1;
								ov_en_c[0] = 1'b1; ov_val_c[0] = imm_q;
								sp_d = sp_q + SP_W'(1);
							end
						end
						OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_USHR: begin
							if (sp_q >= SP_W'(2)) begin
								shift_c = SH_POP1;
								ov_en_c[0] = 1'b1; ov_val_c[0] = alu_r;
								sp_d = sp_q - SP_W'(1);
							end
						end
						OP_MUL: begin
							if (sp_q >= SP_W'(2)) begin
								state_d = S_MUL;
								mcnt_d  = 2'd0;
								sp_d    = sp_q - SP_W'(1);
							end
						end
						OP_DIV: begin
							if (sp_q >= SP_W'(2)) begin
								if (t0 == '0) begin
									term_d = ST_DIVZ;
									ret_d  = '0;
								end else begin
									dreq.start = 1'b1;
									state_d = S_DIV;
									sp_d    = sp_q - SP_W'(1);
								end
							end
						end
						OP_EMIT: begin
							if (sp_q >= SP_W'(1)) begin
								pv_d = 1'b1; pval_d = t0;
								shift_c = SH_POP1;
								sp_d = sp_q - SP_W'(1);
							end
						end
						OP_SWAP: begin
							if (sp_q >= SP_W'(2)) begin
								ov_en_c[1:0] = 2'b11;
								ov_val_c[0] = t1; ov_val_c[1] = t0;
							end
						end
						OP_DUP: begin
							if (sp_q >= SP_W'(1) && sp_q < SP_W'(STACK_DEPTH)) begin
								shift_c = SH_PUSH1;
								ov_en_c[0] = 1'b1; ov_val_c[0] = t0;
								sp_d = sp_q + SP_W'(1);
							end
						end
						OP_DUPX1: begin
							if (sp_q >= SP_W'(2) && sp_q < SP_W'(STACK_DEPTH)) begin
								shift_c = SH_PUSH1;
								ov_en_c[2:0] = 3'b111;
								ov_val_c[0] = t0; ov_val_c[1] = t1; ov_val_c[2] = t0;
								sp_d = sp_q + SP_W'(1);
							end
						end
						OP_DUPX2: begin
							if (sp_q >= SP_W'(3) && sp_q < SP_W'(STACK_DEPTH)) begin
								shift_c = SH_PUSH1;
								ov_en_c[3:0] = 4'hF;
								ov_val_c[0] = t0; ov_val_c[1] = t1;
								ov_val_c[2] = t2; ov_val_c[3] = t0;
								sp_d = sp_q + SP_W'(1);
							end
						end
						OP_DUP2: begin
							if (sp_q >= SP_W'(2) && sp_q < SP_W'(STACK_DEPTH - 1)) begin
								shift_c = SH_PUSH2;
								ov_en_c[1:0] = 2'b11;
								ov_val_c[0] = t0; ov_val_c[1] = t1;
								sp_d = sp_q + SP_W'(2);
							end
						end
						OP_D2X1: begin
							if (sp_q >= SP_W'(3) && sp_q < SP_W'(STACK_DEPTH - 1)) begin
								shift_c = SH_PUSH2;
								ov_en_c[4:0] = 5'h1F;
								ov_val_c[0] = t0; ov_val_c[1] = t1; ov_val_c[2] = t2;
								ov_val_c[3] = t0; ov_val_c[4] = t1;
								sp_d = sp_q + SP_W'(2);
							end
						end
						OP_D2X2: begin
							if (sp_q >= SP_W'(4) && sp_q < SP_W'(STACK_DEPTH - 1)) begin
								shift_c = SH_PUSH2;
								ov_en_c = 6'h3F;
								ov_val_c[0] = t0; ov_val_c[1] = t1; ov_val_c[2] = t2;
								ov_val_c[3] = t3; ov_val_c[4] = t0; ov_val_c[5] = t1;
								sp_d = sp_q + SP_W'(2);
							end
						end
						OP_HJUMP: begin
							if (imm_q < {{(DATA_W-PC_W){1'b0}}, plen_q}) begin
								pc_d = imm_q[PC_W-1:0];
							end
						end
						OP_LOAD: begin
							if (sp_q < SP_W'(STACK_DEPTH) && idx_ok) begin
								state_d = S_LOAD;
								sp_d = sp_q + SP_W'(1);
							end
						end
						OP_SAVE: begin
							if (sp_q >= SP_W'(1) && idx_ok) begin
								lwe = 1'b1;
								shift_c = SH_POP1;
								sp_d = sp_q - SP_W'(1);
							end
						end
						OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFLE, OP_IFGT, OP_IFGE: begin
							if (sp_q >= SP_W'(2)) begin
								shift_c = SH_POP2;
								sp_d = sp_q - SP_W'(2);
								if (taken) begin
									pc_d = pc_sat;
								end
							end
						end
						OP_GOTO: pc_d = pc_sat;
						OP_I2L, OP_I2B, OP_I2C, OP_I2S, OP_L2I, OP_NEG: begin
							if (sp_q >= SP_W'(1)) begin
								ov_en_c[0] = 1'b1; ov_val_c[0] = alu_r;
							end
						end
						OP_HALT: begin
							term_d = ST_HALT;
							ret_d  = top;
						end
						default: ;
					endcase
				end
			end
			S_MUL: begin
				mcnt_d = mcnt_q + 2'd1;
				if (mcnt_q == 2'd1) begin
					acc_d = prod_q;
				end else if (mcnt_q == 2'd2) begin
					acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
				end else if (mcnt_q == 2'd3) begin
					shift_c = SH_POP1;
					ov_en_c[0] = 1'b1; ov_val_c[0] = mul_r;
					state_d = S_RESP;
				end
			end
			S_DIV: begin
				if (drsp.done) begin
					shift_c = SH_POP1;
					ov_en_c[0] = 1'b1; ov_val_c[0] = drsp.quotient;
					state_d = S_RESP;
				end
			end
			S_LOAD: begin
				shift_c = SH_PUSH1;
				ov_en_c[0] = 1'b1; ov_val_c[0] = load_val;
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
				if (post_end) begin
					term_d = ST_END;
					ret_d  = top;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign post_end = (term_q == ST_RUN) && (pc_q >= plen_q);

	// operand stack as a row of cells, index 0 is the top
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] up1, up2, dn1, dn2;
		if (i >= 1) begin : g_u1
			assign up1 = cv[i-1];
		end else begin : g_u1z
			assign up1 = '0;
		end
		if (i >= 2) begin : g_u2
			assign up2 = cv[i-2];
		end else begin : g_u2z
			assign up2 = '0;
		end
		if (i + 1 < STACK_DEPTH) begin : g_d1
			assign dn1 = cv[i+1];
		end else begin : g_d1z
			assign dn1 = '0;
		end
		if (i + 2 < STACK_DEPTH) begin : g_d2
			assign dn2 = cv[i+2];
		end else begin : g_d2z
			assign dn2 = '0;
		end
		assign ctl[i].shift = shift_c;
		if (i < NOV) begin : g_ov
			assign ctl[i].ov_en  = ov_en_c[i];
			assign ctl[i].ov_val = ov_val_c[i];
		end else begin : g_noov
			assign ctl[i].ov_en  = 1'b0;
			assign ctl[i].ov_val = '0;
		end
		smeu_cell u_cell (
			.clk   (clk),
			.ctl   (ctl[i]),
			.up1   (up1),
			.up2   (up2),
			.dn1   (dn1),
			.dn2   (dn2),
			.value (cv[i])
		);
	end

	smeu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (LOCALS_DEPTH)
	) u_locals (
		.clk   (clk),
		.we    (lwe),
		.waddr (lidx),
		.wdata (t0),
		.raddr (lidx),
		.rdata (rdata)
	);

	smeu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			pc_q        <= '0;
			term_q      <= ST_RUN;
			ret_q       <= '0;
			pv_q        <= 1'b0;
			pval_q      <= '0;
			plen_q      <= '0;
			out_valid_q <= 1'b0;
			lvalid_q    <= '0;
			mcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			pc_q    <= pc_d;
			term_q  <= term_d;
			ret_q   <= ret_d;
			pv_q    <= pv_d;
			pval_q  <= pval_d;
			mcnt_q  <= mcnt_d;
			if (cfg_we) begin
				plen_q <= cfg_wdata;
			end
			if (lwe) begin
				lvalid_q[lidx] <= 1'b1;
			end
			if (state_q == S_RESP) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		prod_q <= 64'(mx * my);
		if (in_valid && in_ready) begin
			op_q  <= in_item.action;
			imm_q <= in_item.immediate;
		end
		if (state_q == S_RESP) begin
			out_q.next_pc      <= pc_q;
			out_q.top_value    <= top;
			out_q.stack_depth  <= sp_q;
			out_q.print_valid  <= pv_q;
			out_q.print_value  <= pval_q;
			out_q.run_status   <= post_end ? ST_END : term_q;
			out_q.return_value <= post_end ? top : ((term_q != ST_RUN) ? ret_q : '0);
		end
	end

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: design/smeu_chk.sv
// port checker for the stack machine execute unit, bound to the top level
module smeu_chk
	import smeu_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input out_item_t       out_item
);

	// a result waiting for its taker stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	// a request is only taken when the result slot is free or draining
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_ready)
		else $error("request taken over a pending result");

	a_ret_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.run_status == ST_RUN |-> out_item.return_value == '0)
		else $error("return value while running");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stack_depth == '0 |-> out_item.top_value == '0)
		else $error("top value of an empty stack");

endmodule

bind stack_machine_execute_unit smeu_chk u_smeu_chk (.*);

FILE: dv/stack_machine_execute_unit_test.sv
// testbench for the stack machine execute unit, checked against an in-bench predictor
module stack_machine_execute_unit_test;
	import smeu_pkg::*;

	localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_we;
	logic [PC_W-1:0] cfg_wdata;

	// predictor state
	logic [63:0] stk [STACK_DEPTH];
	logic [63:0] locs [LOCALS_DEPTH];
	int unsigned sp;
	int unsigned pc;
	logic [15:0] plen;
	logic [1:0]  run_code;
	logic [63:0] held_ret;

	out_item_t expected_q [$];
	dir_row_t  dir_rows [$];
	int        errors;
	bit        calm;

	stack_machine_execute_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [63:0] top_entry();
		return (sp > 0) ? stk[sp-1] : 64'd0;
	endfunction

	function automatic void terminate(logic [1:0] code, logic [63:0] value);
		run_code = code;
		held_ret = value;
	endfunction

	function automatic logic [63:0] sext(logic [63:0] v, int bits);
		logic [63:0] m;
		m = 64'd1 << (bits - 1);
		return ((v & ((m << 1) - 64'd1)) ^ m) - m;
	endfunction

	function automatic logic [15:0] sat_target(logic [63:0] imm);
		return (imm > 64'd65535) ? 16'hffff : imm[15:0];
	endfunction

	// runs one instruction on the predictor state and returns the expected result
	function automatic out_item_t exec_instr(in_item_t req);
		logic [5:0]  op;
		logic [63:0] imm, a, b, r, v1, v2, v3, v4, ma, mb, q;
		int unsigned np;
		bit          pv, taken;
		logic [63:0] pval;
		out_item_t   o;
		op = req.action;
		imm = req.immediate;
		pv = 1'b0;
		pval = '0;
		r = '0;
		taken = 1'b0;
		if (run_code == ST_RUN && pc >= plen)
			terminate(ST_END, top_entry());
		if (run_code == ST_RUN) begin
			np = (pc + 1 > 65535) ? 65535 : pc + 1;
			case (op)
			OP_PUSH: if (sp < STACK_DEPTH) begin
				stk[sp] = imm;
				sp++;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_USHR:
				if (sp >= 2) begin
					a = stk[sp-2];
					b = stk[sp-1];
					case (op)
					OP_ADD:  r = a + b;
					OP_SUB:  r = a - b;
					OP_MUL:  r = a * b;
					OP_AND:  r = a & b;
					OP_OR:   r = a | b;
					OP_XOR:  r = a ^ b;
					OP_SHL:  r = a << b[5:0];
					OP_SHR:  r = $signed(a) >>> b[5:0];
					default: r = a >> b[5:0];
					endcase
					stk[sp-2] = r;
					sp--;
				end
			OP_DIV: if (sp >= 2) begin
				a = stk[sp-2];
				b = stk[sp-1];
				if (b == 0) begin
					terminate(ST_DIVZ, 64'd0);
				end else begin
					ma = a[63] ? -a : a;
					mb = b[63] ? -b : b;
					q = ma / mb;
					stk[sp-2] = (a[63] != b[63]) ? -q : q;
					sp--;
				end
			end
			OP_EMIT: if (sp >= 1) begin
				sp--;
				pv = 1'b1;
				pval = stk[sp];
			end
			OP_SWAP: if (sp >= 2) begin
				v1 = stk[sp-1];
				stk[sp-1] = stk[sp-2];
				stk[sp-2] = v1;
			end
			OP_DUP: if (sp >= 1 && sp < STACK_DEPTH) begin
				stk[sp] = stk[sp-1];
				sp++;
			end
			OP_DUPX1: if (sp >= 2 && sp < STACK_DEPTH) begin
				v1 = stk[sp-1];
				v2 = stk[sp-2];
				stk[sp-2] = v1;
				stk[sp-1] = v2;
				stk[sp] = v1;
				sp++;
			end
			OP_DUPX2: if (sp >= 3 && sp < STACK_DEPTH) begin
				v1 = stk[sp-1];
				v2 = stk[sp-2];
				v3 = stk[sp-3];
				stk[sp-3] = v1;
				stk[sp-2] = v3;
				stk[sp-1] = v2;
				stk[sp] = v1;
				sp++;
			end
			OP_DUP2: if (sp >= 2 && sp + 1 < STACK_DEPTH) begin
				v1 = stk[sp-1];
				v2 = stk[sp-2];
				stk[sp] = v2;
				stk[sp+1] = v1;
				sp += 2;
			end
			OP_D2X1: if (sp >= 3 && sp + 1 < STACK_DEPTH) begin
				v1 = stk[sp-1];
				v2 = stk[sp-2];
				v3 = stk[sp-3];
				stk[sp-3] = v2;
				stk[sp-2] = v1;
				stk[sp-1] = v3;
				stk[sp] = v2;
				stk[sp+1] = v1;
				sp += 2;
			end
			OP_D2X2: if (sp >= 4 && sp + 1 < STACK_DEPTH) begin
				v1 = stk[sp-1];
				v2 = stk[sp-2];
				v3 = stk[sp-3];
				v4 = stk[sp-4];
				stk[sp-4] = v2;
				stk[sp-3] = v1;
				stk[sp-2] = v4;
				stk[sp-1] = v3;
				stk[sp] = v2;
				stk[sp+1] = v1;
				sp += 2;
			end
			OP_HJUMP: if (imm < {48'd0, plen}) np = 32'(imm[15:0]);
			OP_LOAD: if (sp < STACK_DEPTH && imm < LOCALS_DEPTH) begin
				stk[sp] = locs[imm[7:0]];
				sp++;
			end
			OP_SAVE: if (sp >= 1 && imm < LOCALS_DEPTH) begin
				sp--;
				locs[imm[7:0]] = stk[sp];
			end
			OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFLE, OP_IFGT, OP_IFGE: if (sp >= 2) begin
				b = stk[sp-1];
				a = stk[sp-2];
				sp -= 2;
				case (op)
				OP_IFEQ: taken = (a == b);
				OP_IFNE: taken = (a != b);
				OP_IFLT: taken = $signed(a) < $signed(b);
				OP_IFLE: taken = $signed(a) <= $signed(b);
				OP_IFGT: taken = $signed(a) > $signed(b);
				default: taken = $signed(a) >= $signed(b);
				endcase
				if (taken) np = 32'(sat_target(imm));
			end
			OP_GOTO: np = 32'(sat_target(imm));
			OP_I2L, OP_L2I: if (sp >= 1) stk[sp-1] = sext(stk[sp-1], 32);
			OP_I2B: if (sp >= 1) stk[sp-1] = sext(stk[sp-1], 8);
			OP_I2C: if (sp >= 1) stk[sp-1] = stk[sp-1] & 64'hffff;
			OP_I2S: if (sp >= 1) stk[sp-1] = sext(stk[sp-1], 16);
			OP_NEG: if (sp >= 1) stk[sp-1] = -stk[sp-1];
			OP_HALT: terminate(ST_HALT, top_entry());
			default: ;
			endcase
			pc = np;
			if (run_code == ST_RUN && pc >= plen)
				terminate(ST_END, top_entry());
		end
		o.next_pc = pc[15:0];
		o.top_value = top_entry();
		o.stack_depth = sp[SP_W-1:0];
		o.print_valid = pv;
		o.print_value = pval;
		o.run_status = run_code;
		o.return_value = (run_code != ST_RUN) ? held_ret : 64'd0;
		return o;
	endfunction

	function automatic out_item_t mk_out(int unsigned npc, logic [63:0] top, int unsigned depth,
		bit pv, logic [63:0] pval);
		out_item_t o;
		o.next_pc = npc[15:0];
		o.top_value = top;
		o.stack_depth = depth[SP_W-1:0];
		o.print_valid = pv;
		o.print_value = pval;
		o.run_status = ST_RUN;
		o.return_value = '0;
		return o;
	endfunction

	function automatic void add_row(logic [5:0] op, logic [63:0] imm);
		dir_row_t row;
		row.req.action = op;
		row.req.immediate = imm;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_typed(logic [5:0] op, logic [63:0] imm, out_item_t want);
		dir_row_t row;
		row.req.action = op;
		row.req.immediate = imm;
		row.typed = 1'b1;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
		0:       return MAX_S;
		1:       return MIN_S;
		2:       return '1;
		3:       return '0;
		4, 5:    return 64'($urandom_range(0, 40)) - 64'd20;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// random instruction steered by mode: 0 mixed, 1 grow the stack, 2 shrink it
	function automatic in_item_t gen_item(int mode);
		in_item_t req;
		logic [5:0] op;
		int r;
		r = $urandom_range(0, 99);
		if (mode == 1 && r < 85)
			op = (r < 55) ? OP_PUSH : (r < 65) ? OP_LOAD : 6'($urandom_range(8, 13));
		else if (mode == 2 && r < 70)
			op = (r < 20) ? OP_EMIT : (r < 35) ? OP_SAVE :
				(r < 50) ? 6'($urandom_range(17, 22)) : 6'($urandom_range(24, 29));
		else if (r < 3)
			op = 6'($urandom_range(37, 63));
		else
			op = 6'($urandom_range(0, 35));
		// keep the run alive: no zero divisor here
		if (op == OP_DIV && sp >= 2 && stk[sp-1] == 0)
			op = OP_ADD;
		req.action = op;
		case (op)
		OP_PUSH: req.immediate = rand_word();
		OP_LOAD, OP_SAVE:
			case ($urandom_range(0, 5))
			0:       req.immediate = {$urandom, $urandom};
			1:       req.immediate = 64'($urandom_range(254, 257));
			default: req.immediate = 64'($urandom_range(0, 15));
			endcase
		OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFLE, OP_IFGT, OP_IFGE, OP_GOTO:
			req.immediate = 64'($urandom_range(0, 999));
		OP_HJUMP:
			req.immediate = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
				64'($urandom_range(0, int'(plen) + 20));
		default: req.immediate = {$urandom, $urandom};
		endcase
		return req;
	endfunction

	task automatic send_req(in_item_t req, bit typed, out_item_t want);
		int gap;
		out_item_t got;
		gap = 0;
		if (!calm)
			case ($urandom_range(0, 9))
			0, 1, 2: gap = $urandom_range(1, 3);
			3:       gap = $urandom_range(5, 30);
			default: gap = 0;
			endcase
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = exec_instr(req);
		expected_q.push_back(typed ? want : got);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_len(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		plen = v;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	// result side
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm) begin
				out_ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 19))
				0:          begin
					out_ready <= 1'b0;
					repeat ($urandom_range(5, 30)) @(posedge clk);
				end
				1, 2, 3, 4, 5: out_ready <= 1'b0;
				default:    out_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("unrequested result pc", 64'(out_item.next_pc), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (out_item.next_pc !== want.next_pc)
					report("next_pc", 64'(out_item.next_pc), 64'(want.next_pc));
				if (out_item.top_value !== want.top_value)
					report("top_value", out_item.top_value, want.top_value);
				if (out_item.stack_depth !== want.stack_depth)
					report("stack_depth", 64'(out_item.stack_depth), 64'(want.stack_depth));
				if (out_item.print_valid !== want.print_valid)
					report("print_valid", 64'(out_item.print_valid), 64'(want.print_valid));
				if (out_item.print_value !== want.print_value)
					report("print_value", out_item.print_value, want.print_value);
				if (out_item.run_status !== want.run_status)
					report("run_status", 64'(out_item.run_status), 64'(want.run_status));
				if (out_item.return_value !== want.return_value)
					report("return_value", out_item.return_value, want.return_value);
			end
		end
	end

	initial begin
		int mode, kind, lim;
		in_item_t req;
		errors = 0;
		calm = 1'b0;
		sp = 0;
		pc = 0;
		plen = '0;
		run_code = ST_RUN;
		held_ret = '0;
		for (int i = 0; i < LOCALS_DEPTH; i++) locs[i] = '0;
		for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_len(16'hffff);

		// empty stack add, extremes, divide overflow, print
		add_typed(OP_ADD, 64'd0, mk_out(1, 64'd0, 0, 1'b0, 64'd0));
		add_typed(OP_PUSH, MAX_S, mk_out(2, MAX_S, 1, 1'b0, 64'd0));
		add_typed(OP_PUSH, MIN_S, mk_out(3, MIN_S, 2, 1'b0, 64'd0));
		add_typed(OP_PUSH, '1, mk_out(4, '1, 3, 1'b0, 64'd0));
		add_typed(OP_DIV, 64'd0, mk_out(5, MIN_S, 2, 1'b0, 64'd0));
		add_typed(OP_EMIT, 64'd0, mk_out(6, MAX_S, 1, 1'b1, MIN_S));
		add_row(OP_PUSH, 64'd65);
		add_row(OP_SHL, 64'd0);
		add_row(OP_PUSH, -64'sd8);
		add_row(OP_PUSH, 64'd2);
		add_row(OP_SHR, 64'd0);
		add_row(OP_PUSH, 64'd2);
		add_row(OP_USHR, 64'd0);
		add_row(OP_DUP, 64'd0);
		add_row(OP_DUPX1, 64'd0);
		add_row(OP_DUPX2, 64'd0);
		add_row(OP_DUP2, 64'd0);
		add_row(OP_D2X1, 64'd0);
		add_row(OP_D2X2, 64'd0);
		add_row(OP_SWAP, 64'd0);
		add_row(OP_AND, 64'd0);
		add_row(OP_OR, 64'd0);
		add_row(OP_XOR, 64'd0);
		add_row(OP_MUL, 64'd0);
		add_row(OP_SUB, 64'd0);
		add_row(OP_I2L, 64'd0);
		add_row(OP_I2B, 64'd0);
		add_row(OP_I2C, 64'd0);
		add_row(OP_I2S, 64'd0);
		add_row(OP_L2I, 64'd0);
		add_row(OP_NEG, 64'd0);
		add_row(OP_SAVE, 64'd3);
		add_row(OP_SAVE, 64'd300);
		add_row(OP_LOAD, 64'd3);
		add_row(OP_LOAD, '1);
		add_row(OP_HJUMP, 64'd50);
		add_row(OP_HJUMP, '1);
		add_row(OP_PUSH, 64'd4);
		add_row(OP_PUSH, 64'd4);
		add_row(OP_IFEQ, 64'd10);
		add_row(OP_GOTO, 64'd20);
		add_row(OP_NOP, 64'd0);
		add_row(6'd63, '1);
		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// random phases: mixed, grow, grow, shrink, mixed
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			calm = ($urandom_range(0, 3) == 0);
			// leave room for a thousand steps past the current pc where the pc range allows it
			lim = (int'(pc) > 64535) ? 65535 :
				int'(pc) + 1000 + int'($urandom_range(0, 64535 - int'(pc)));
			write_len((ph == 0) ? 16'hffff : lim[15:0]);
			mode = (ph == 1 || ph == 2) ? 1 : (ph == 3) ? 2 : 0;
			repeat (220) send_req(gen_item(mode), 1'b0, '0);
		end

		// end the run one way: halt, divide by zero, program end or branch past the end
		drain();
		calm = 1'b0;
		kind = $urandom_range(0, 3);
		req.immediate = '0;
		case (kind)
		0: req.action = OP_HALT;
		1: begin
			req.action = OP_PUSH;
			send_req(req, 1'b0, '0);
			req.action = OP_DIV;
		end
		2: begin
			drain();
			write_len(pc[15:0]);
			req.action = OP_NOP;
		end
		default: begin
			req.action = OP_GOTO;
			req.immediate = '1;
		end
		endcase
		send_req(req, 1'b0, '0);
		repeat (4) begin
			req.action = 6'($urandom_range(0, 63));
			req.immediate = rand_word();
			send_req(req, 1'b0, '0);
		end
		drain();
		write_len(16'd0);
		repeat (3) send_req(gen_item(0), 1'b0, '0);
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
